FILE: src/qerase_pkg.sv
// ----------------------------------------------------------------------------
// qerase_pkg
// Shared types and constants for the queue with erase at a position.
// ----------------------------------------------------------------------------
package qerase_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int ENTRY_WIDTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Wide enough for a count or a cell index at the largest supported depth.
  localparam int IDX_W = 9;

  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ERASE = 2'd2;

  typedef struct packed {
    logic             push;
    logic             shift;
    logic [IDX_W-1:0] gap;
    logic [IDX_W-1:0] tail;
  } cell_ctl_t;

endpackage

FILE: src/qerase_cell.sv
// ----------------------------------------------------------------------------
// qerase_cell
// One queue slot. It takes its neighbor's entry when a gap opens at or below
// it, or loads the pushed handle when it is the tail slot.
// ----------------------------------------------------------------------------
module qerase_cell #(
  parameter int ENTRY_WIDTH = qerase_pkg::ENTRY_WIDTH_DEF,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  qerase_pkg::cell_ctl_t  ctl,
  input  logic [ENTRY_WIDTH-1:0] push_value,
  input  logic [ENTRY_WIDTH-1:0] next_value,
  output logic [ENTRY_WIDTH-1:0] value
);

  localparam logic [qerase_pkg::IDX_W-1:0] IDX = qerase_pkg::IDX_W'(INDEX);

  logic [ENTRY_WIDTH-1:0] data_r;
  logic [ENTRY_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift && (IDX >= ctl.gap)) begin
      data_nxt = next_value;
    end else if (ctl.push && (IDX == ctl.tail)) begin
      data_nxt = push_value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign value = data_r;

endmodule

FILE: src/qerase_ctrl.sv
// ----------------------------------------------------------------------------
// qerase_ctrl
// Holds the entry count, decides each request's outcome, drives the cell
// row and registers the result.
// ----------------------------------------------------------------------------
module qerase_ctrl #(
  parameter int DEPTH = qerase_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [qerase_pkg::ACTION_W-1:0]     action,
  input  logic [qerase_pkg::POS_W-1:0]        position,
  input  logic [qerase_pkg::VALUE_W-1:0]      head_value,
  output qerase_pkg::cell_ctl_t               ctl,
  output logic                                res_valid,
  output logic                                res_ok,
  output logic [qerase_pkg::VALUE_W-1:0]      res_popped,
  output logic [qerase_pkg::COUNT_W-1:0]      res_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IW    = qerase_pkg::IDX_W;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             valid_r, ok_r;
  logic             ok_nxt;
  logic [qerase_pkg::VALUE_W-1:0] popped_r, popped_nxt;
  logic [IW-1:0]    cnt_wide;
  logic [IW-1:0]    pos_wide;
  logic [IW+qerase_pkg::COUNT_W-1:0] cnt_out_ext;

  assign cnt_wide = IW'(cnt_r);
  assign pos_wide = IW'(position);

  always_comb begin
    ctl        = '0;
    ctl.tail   = cnt_wide;
    ok_nxt     = 1'b0;
    popped_nxt = '0;
    cnt_nxt    = cnt_r;
    if (accept) begin
      unique case (action)
        qerase_pkg::ACT_PUSH: begin
          if (cnt_r != CNT_W'(DEPTH)) begin
            ctl.push = 1'b1;
            ok_nxt   = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        qerase_pkg::ACT_POP: begin
          if (cnt_r != '0) begin
            ctl.shift  = 1'b1;
            ok_nxt     = 1'b1;
            popped_nxt = head_value;
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
        end
        qerase_pkg::ACT_ERASE: begin
          if (pos_wide < cnt_wide) begin
            ctl.shift = 1'b1;
            ctl.gap   = pos_wide;
            ok_nxt    = 1'b1;
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= accept;
      ok_r    <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
  end

  assign cnt_out_ext = {{qerase_pkg::COUNT_W{1'b0}}, cnt_wide};
  assign res_valid   = valid_r;
  assign res_ok      = ok_r;
  assign res_popped  = popped_r;
  assign res_count   = cnt_out_ext[qerase_pkg::COUNT_W-1:0];

endmodule

FILE: src/queue_with_erase_at_position_core.sv
// ----------------------------------------------------------------------------
// queue_with_erase_at_position_core
// Ordered queue of handles with push, pop and erase at a position. Every
// slot is a cell that moves up from its neighbor when a gap opens at or below it.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; busy is never raised.
// Compaction is done by all cells at or above the gap in the same cycle.
// Reset clears the entry count; slot contents are undefined until written.
// The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module queue_with_erase_at_position_core #(
  parameter int DEPTH       = qerase_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = qerase_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [qerase_pkg::ACTION_W-1:0]     in_action,
  input  logic [qerase_pkg::VALUE_W-1:0]      in_entry_value,
  input  logic [qerase_pkg::POS_W-1:0]        in_position,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic [qerase_pkg::VALUE_W-1:0]      out_popped_value,
  output logic [qerase_pkg::COUNT_W-1:0]      out_entry_count
);

  localparam int VW = qerase_pkg::VALUE_W;

  qerase_pkg::cell_ctl_t  ctl;
  logic                   accept;
  logic [ENTRY_WIDTH-1:0] cell_value [DEPTH];
  logic [ENTRY_WIDTH-1:0] push_value;
  logic [ENTRY_WIDTH+VW-1:0] in_ext;
  logic [ENTRY_WIDTH+VW-1:0] head_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_ext     = {{ENTRY_WIDTH{1'b0}}, in_entry_value};
  assign push_value = in_ext[ENTRY_WIDTH-1:0];
  assign head_ext   = {{VW{1'b0}}, cell_value[0]};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      qerase_cell #(.ENTRY_WIDTH(ENTRY_WIDTH), .INDEX(i)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .push_value (push_value),
        .next_value (cell_value[i]),
        .value      (cell_value[i])
      );
    end else begin : g_mid
      qerase_cell #(.ENTRY_WIDTH(ENTRY_WIDTH), .INDEX(i)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .push_value (push_value),
        .next_value (cell_value[i+1]),
        .value      (cell_value[i])
      );
    end
  end

  qerase_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .action     (in_action),
    .position   (in_position),
    .head_value (head_ext[VW-1:0]),
    .ctl        (ctl),
    .res_valid  (out_valid),
    .res_ok     (out_ok),
    .res_popped (out_popped_value),
    .res_count  (out_entry_count)
  );

endmodule

FILE: src/qerase_checker.sv
// ----------------------------------------------------------------------------
// qerase_checker
// Port-level checks on the queue's results over time.
// ----------------------------------------------------------------------------
module qerase_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [qerase_pkg::ACTION_W-1:0]     in_action,
  input logic                                out_valid,
  input logic                                out_ok,
  input logic [qerase_pkg::VALUE_W-1:0]      out_popped_value,
  input logic [qerase_pkg::COUNT_W-1:0]      out_entry_count
);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("A request produced no result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("A result appeared without a request.");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action != qerase_pkg::ACT_POP) |=> (out_popped_value == '0))
    else $error("A non-pop request returned a popped handle.");

  a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_popped_value == '0))
    else $error("A failed request returned a popped handle.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok && $past(out_valid) && $past(in_action) == qerase_pkg::ACT_PUSH)
      |-> (out_entry_count == $past(out_entry_count) + qerase_pkg::COUNT_W'(1)))
    else $error("A successful push did not raise the count by one.");

endmodule

bind queue_with_erase_at_position_core qerase_checker u_qerase_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_ok           (out_ok),
  .out_popped_value (out_popped_value),
  .out_entry_count  (out_entry_count)
);

FILE: bench/queue_with_erase_at_position_core_tb.sv
// ----------------------------------------------------------------------------
// queue_with_erase_at_position_core_tb
// Self-checking bench for the queue with push, pop and erase at a position.
// Requests are sent with random gaps, none in the last phase. A behavioral copy
// of the queue predicts the flag, popped handle and count of every result. The
// directed tests cover the empty and full cases, out-of-range erases and the
// unused action code. The random tests then run a phase weighted to fill the
// queue, one weighted to drain it and a balanced one.
// ----------------------------------------------------------------------------
module queue_with_erase_at_position_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = qerase_pkg::DEPTH_DEF;
  localparam logic [qerase_pkg::ACTION_W-1:0] ACT_NOOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int OUTCOME_SLOTS = 16;

  typedef struct packed {
    logic                           ok;
    logic [qerase_pkg::VALUE_W-1:0] popped;
    logic [qerase_pkg::COUNT_W-1:0] count;
  } queue_outcome_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic [qerase_pkg::ACTION_W-1:0] in_action = qerase_pkg::ACT_PUSH;
  logic [qerase_pkg::VALUE_W-1:0]  in_entry_value = '0;
  logic [qerase_pkg::POS_W-1:0]    in_position = '0;
  logic                            busy;
  logic                            out_valid;
  logic                            out_ok;
  logic [qerase_pkg::VALUE_W-1:0]  out_popped_value;
  logic [qerase_pkg::COUNT_W-1:0]  out_entry_count;

  logic [qerase_pkg::VALUE_W-1:0] queue_slots [QDEPTH];
  int                             queue_count = 0;
  queue_outcome_t                 outcome_store [OUTCOME_SLOTS];
  int                             outcome_wr = 0;
  int                             outcome_rd = 0;
  int                             error_count = 0;
  int                             idle_limit = 4;
  int                             cycle_count = 0;

  queue_with_erase_at_position_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_entry_value   (in_entry_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_popped_value (out_popped_value),
    .out_entry_count  (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("queue_with_erase_at_position_core_tb: done, errors");
      $finish;
    end
  end

  function automatic queue_outcome_t apply_queue_action(
      input logic [qerase_pkg::ACTION_W-1:0] act,
      input logic [qerase_pkg::VALUE_W-1:0]  value,
      input logic [qerase_pkg::POS_W-1:0]    pos);
    queue_outcome_t res;
    int i;
    res = '0;
    unique case (act)
      qerase_pkg::ACT_PUSH: begin
        if (queue_count < QDEPTH) begin
          queue_slots[queue_count] = value;
          queue_count++;
          res.ok = 1'b1;
        end
      end
      qerase_pkg::ACT_POP: begin
        if (queue_count > 0) begin
          res.popped = queue_slots[0];
          for (i = 0; i + 1 < queue_count; i++) queue_slots[i] = queue_slots[i + 1];
          queue_count--;
          res.ok = 1'b1;
        end
      end
      qerase_pkg::ACT_ERASE: begin
        if (int'(pos) < queue_count) begin
          for (i = int'(pos); i + 1 < queue_count; i++) queue_slots[i] = queue_slots[i + 1];
          queue_count--;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = queue_count[qerase_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    queue_outcome_t want;
    if (rst_n && out_valid) begin
      if (outcome_wr == outcome_rd) begin
        report_mismatch("unexpected result", out_entry_count, 0);
      end else begin
        want = outcome_store[outcome_rd % OUTCOME_SLOTS];
        outcome_rd++;
        if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
        if (out_popped_value !== want.popped)
          report_mismatch("popped_value", out_popped_value, want.popped);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
    end
  end

  task automatic send_request(input logic [qerase_pkg::ACTION_W-1:0] act,
                              input logic [qerase_pkg::VALUE_W-1:0]  value,
                              input logic [qerase_pkg::POS_W-1:0]    pos);
    int gap;
    gap = $urandom_range(idle_limit, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_entry_value <= value;
    in_position    <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    outcome_store[outcome_wr % OUTCOME_SLOTS] = apply_queue_action(act, value, pos);
    outcome_wr++;
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (outcome_wr != outcome_rd);
  endtask

  task automatic test_empty_queue();
    send_request(qerase_pkg::ACT_POP, 32'hFFFF_FFFF, 4'd0);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd0);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd15);
    send_request(ACT_NOOP, 32'hFFFF_FFFF, 4'd15);
  endtask

  task automatic test_edge_values();
    send_request(qerase_pkg::ACT_PUSH, 32'h0, 4'd15);
    send_request(qerase_pkg::ACT_PUSH, 32'hFFFF_FFFF, 4'd0);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd2);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd15);
    send_request(qerase_pkg::ACT_POP, 32'h0, 4'd0);
    send_request(ACT_NOOP, 32'h1234_5678, 4'd0);
    send_request(qerase_pkg::ACT_ERASE, 32'hFFFF_FFFF, 4'd0);
  endtask

  // The queue is filled to the brim, then trimmed from the tail, the head
  // and by pops. It finishes with a pause until every result has come back.
  task automatic test_full_queue();
    int k;
    for (k = 0; k < QDEPTH; k++) send_request(qerase_pkg::ACT_PUSH, $urandom, 4'($urandom));
    send_request(qerase_pkg::ACT_PUSH, $urandom, 4'd0);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd15);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd15);
    send_request(qerase_pkg::ACT_ERASE, 32'h0, 4'd0);
    send_request(qerase_pkg::ACT_POP, 32'h0, 4'd0);
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int n_requests, input int push_pct);
    int k;
    int pick;
    logic [qerase_pkg::POS_W-1:0] pos;
    for (k = 0; k < n_requests; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < push_pct) begin
        send_request(qerase_pkg::ACT_PUSH, $urandom, 4'($urandom));
      end else begin
        pick = $urandom_range(19, 0);
        if (pick < 8) begin
          send_request(qerase_pkg::ACT_POP, $urandom, 4'($urandom));
        end else if (pick < 16) begin
          if (queue_count > 0) pos = 4'($urandom_range(queue_count - 1, 0));
          else pos = 4'($urandom);
          send_request(qerase_pkg::ACT_ERASE, $urandom, pos);
        end else if (pick < 18) begin
          send_request(qerase_pkg::ACT_ERASE, $urandom, 4'($urandom));
        end else begin
          send_request(ACT_NOOP, $urandom, 4'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_edge_values();
    test_full_queue();

    test_random_mix(250, 70);
    wait_for_drain();
    test_random_mix(250, 30);
    idle_limit = 0;
    test_random_mix(200, 50);

    start <= 1'b0;
    while (outcome_wr != outcome_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("queue_with_erase_at_position_core_tb: done, clean");
    end else begin
      $display("queue_with_erase_at_position_core_tb: done, errors");
    end
    $finish;
  end

endmodule
